// File: sv/rlz_pkg.sv
// Shared constants and types of the streaming RefPack decompressor.
`timescale 1ns / 1ps
`default_nettype none
package rlz_pkg;

  localparam int WINDOW_BYTES = 131072;
  localparam int WIN_AW       = $clog2(WINDOW_BYTES);
  localparam int PROD_W       = WIN_AW + 1;
  localparam int DIST_W       = 18;
  localparam int LEN_W        = 11;
  localparam int OUT_BYTES    = 32;
  localparam int LANE_AW      = $clog2(OUT_BYTES);
  localparam int CNT_W        = 6;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_DIST  = 2'd1;
  localparam logic [1:0] ST_AFTER_END = 2'd2;

  typedef struct packed {
    logic              restart;
    logic              emit_lit;
    logic [7:0]        lit_byte;
    logic              do_copy;
    logic [LEN_W-1:0]  copy_len;
    logic [DIST_W-1:0] copy_dist;
    logic              size_valid;
    logic [23:0]       decoded_size;
    logic              stream_end;
    logic              after_end;
    logic [31:0]       consumed;
  } act_t;

endpackage
`default_nettype wire

// File: sv/rlz_hist_ram.sv
// History window memory with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module rlz_hist_ram #(
  parameter int DEPTH = 131072,
  parameter int WIDTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// File: sv/rlz_packer.sv
// Output byte lanes that collect produced bytes into one result.
`timescale 1ns / 1ps
`default_nettype none
module rlz_packer (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          push,
  input  wire logic [7:0]                    push_byte,
  input  wire logic                          clear,
  output logic                               full,
  output logic [rlz_pkg::CNT_W-1:0]          count,
  output logic [rlz_pkg::OUT_BYTES*8-1:0]    data
);

  logic [7:0]                lanes_r [rlz_pkg::OUT_BYTES];
  logic [rlz_pkg::CNT_W-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      cnt_r <= '0;
      for (int i = 0; i < rlz_pkg::OUT_BYTES; i++) begin
        lanes_r[i] <= 8'd0;
      end
    end else if (push) begin
      lanes_r[cnt_r[rlz_pkg::LANE_AW-1:0]] <= push_byte;
      cnt_r <= cnt_r + 1'b1;
    end
  end

  always_comb begin
    for (int i = 0; i < rlz_pkg::OUT_BYTES; i++) begin
      data[i*8 +: 8] = lanes_r[i];
    end
  end

  assign full  = (cnt_r == rlz_pkg::CNT_W'(rlz_pkg::OUT_BYTES));
  assign count = cnt_r;

endmodule
`default_nettype wire

// File: sv/rlz_parser.sv
// Header and command parser that turns one compressed byte into actions.
`timescale 1ns / 1ps
`default_nettype none
module rlz_parser (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          step,
  input  wire logic [7:0]    in_byte,
  input  wire logic          begin_req,
  output rlz_pkg::act_t      act
);

  localparam logic [2:0] PH_FLAG = 3'd0;
  localparam logic [2:0] PH_SKIP = 3'd1;
  localparam logic [2:0] PH_SIZE = 3'd2;
  localparam logic [2:0] PH_OP   = 3'd3;
  localparam logic [2:0] PH_CMD  = 3'd4;
  localparam logic [2:0] PH_LIT  = 3'd5;
  localparam logic [2:0] PH_DONE = 3'd6;

  logic [2:0]                  phase_r, phase_nxt;
  logic [2:0]                  hl_r, hl_nxt;
  logic [23:0]                 size_r, size_nxt;
  logic [7:0]                  c0_r, c0_nxt, c1_r, c1_nxt, c2_r, c2_nxt;
  logic [1:0]                  got_r, got_nxt;
  logic [6:0]                  lits_r, lits_nxt;
  logic [rlz_pkg::LEN_W-1:0]   clen_r, clen_nxt;
  logic [rlz_pkg::DIST_W-1:0]  cdist_r, cdist_nxt;
  logic                        endp_r, endp_nxt;
  logic [31:0]                 cons_r, cons_nxt;

  logic [7:0]                  f0, f1, f2, f3;
  logic                        fin;
  logic [2:0]                  need;

  always_comb begin
    phase_nxt = begin_req ? PH_FLAG : phase_r;
    hl_nxt    = begin_req ? 3'd0 : hl_r;
    size_nxt  = begin_req ? 24'd0 : size_r;
    c0_nxt    = begin_req ? 8'd0 : c0_r;
    c1_nxt    = begin_req ? 8'd0 : c1_r;
    c2_nxt    = begin_req ? 8'd0 : c2_r;
    got_nxt   = begin_req ? 2'd0 : got_r;
    lits_nxt  = begin_req ? 7'd0 : lits_r;
    clen_nxt  = begin_req ? '0 : clen_r;
    cdist_nxt = begin_req ? '0 : cdist_r;
    endp_nxt  = begin_req ? 1'b0 : endp_r;
    cons_nxt  = begin_req ? 32'd0 : cons_r;
    fin = 1'b0;
    f0 = c0_nxt;
    f1 = c1_nxt;
    f2 = c2_nxt;
    f3 = in_byte;
    need = 3'd0;
    act = '0;
    act.restart  = begin_req;
    act.lit_byte = in_byte;
    if (phase_nxt == PH_DONE) begin
      act.after_end = 1'b1;
    end else begin
      if (cons_nxt != 32'hFFFF_FFFF) begin
        cons_nxt = cons_nxt + 32'd1;
      end
      case (phase_nxt)
        PH_FLAG: begin
          hl_nxt    = in_byte[0] ? 3'd4 : 3'd1;
          phase_nxt = PH_SKIP;
        end
        PH_SKIP: begin
          hl_nxt = hl_nxt - 3'd1;
          if (hl_nxt == 3'd0) begin
            phase_nxt = PH_SIZE;
            hl_nxt    = 3'd3;
            size_nxt  = 24'd0;
          end
        end
        PH_SIZE: begin
          size_nxt = {size_nxt[15:0], in_byte};
          hl_nxt   = hl_nxt - 3'd1;
          if (hl_nxt == 3'd0) begin
            act.size_valid   = 1'b1;
            act.decoded_size = size_nxt;
            phase_nxt        = PH_OP;
          end
        end
        PH_OP: begin
          c0_nxt   = in_byte;
          got_nxt  = 2'd1;
          endp_nxt = 1'b0;
          f0 = in_byte;
          if (in_byte >= 8'hE0) begin
            fin = 1'b1;
          end else begin
            phase_nxt = PH_CMD;
          end
        end
        PH_CMD: begin
          case (got_nxt)
            2'd1:    c1_nxt = in_byte;
            2'd2:    c2_nxt = in_byte;
            default: ;
          endcase
          f1 = c1_nxt;
          f2 = c2_nxt;
          need = (c0_nxt < 8'h80) ? 3'd2 : ((c0_nxt < 8'hC0) ? 3'd3 : 3'd4);
          if ({1'b0, got_nxt} + 3'd1 >= need) begin
            fin = 1'b1;
          end
          got_nxt = got_nxt + 2'd1;
        end
        PH_LIT: begin
          act.emit_lit = 1'b1;
          if (lits_nxt != 7'd0) begin
            lits_nxt = lits_nxt - 7'd1;
          end
          if (lits_nxt == 7'd0) begin
            if (endp_nxt) begin
              phase_nxt      = PH_DONE;
              act.stream_end = 1'b1;
            end else begin
              if (clen_nxt != '0) begin
                act.do_copy = 1'b1;
              end
              phase_nxt = PH_OP;
            end
          end
        end
        default: begin
          phase_nxt     = PH_DONE;
          act.after_end = 1'b1;
        end
      endcase
      if (fin) begin
        if (f0 >= 8'hE0) begin
          clen_nxt = '0;
          if (f0 >= 8'hFC) begin
            endp_nxt = 1'b1;
            lits_nxt = {5'd0, f0[1:0]};
            if (f0[1:0] == 2'd0) begin
              phase_nxt      = PH_DONE;
              act.stream_end = 1'b1;
            end else begin
              phase_nxt = PH_LIT;
            end
          end else begin
            lits_nxt  = {f0[4:0], 2'b00} + 7'd4;
            phase_nxt = PH_LIT;
          end
        end else begin
          if (f0 < 8'h80) begin
            lits_nxt  = {5'd0, f0[1:0]};
            clen_nxt  = rlz_pkg::LEN_W'(f0[4:2]) + rlz_pkg::LEN_W'(3);
            cdist_nxt = rlz_pkg::DIST_W'({f0[6:5], f1}) + rlz_pkg::DIST_W'(1);
          end else if (f0 < 8'hC0) begin
            lits_nxt  = {5'd0, f1[7:6]};
            clen_nxt  = rlz_pkg::LEN_W'(f0[5:0]) + rlz_pkg::LEN_W'(4);
            cdist_nxt = rlz_pkg::DIST_W'({f1[5:0], f2}) + rlz_pkg::DIST_W'(1);
          end else begin
            lits_nxt  = {5'd0, f0[1:0]};
            clen_nxt  = rlz_pkg::LEN_W'({f0[3:2], 8'd0}) + rlz_pkg::LEN_W'(f3)
                        + rlz_pkg::LEN_W'(5);
            cdist_nxt = rlz_pkg::DIST_W'({f0[4], f1, f2}) + rlz_pkg::DIST_W'(1);
          end
          if (lits_nxt == 7'd0) begin
            act.do_copy = 1'b1;
            phase_nxt   = PH_OP;
          end else begin
            phase_nxt = PH_LIT;
          end
        end
      end
      act.copy_len  = clen_nxt;
      act.copy_dist = cdist_nxt;
      if (act.do_copy) begin
        clen_nxt = '0;
      end
    end
    act.consumed = cons_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FLAG;
      hl_r    <= 3'd0;
      size_r  <= 24'd0;
      c0_r    <= 8'd0;
      c1_r    <= 8'd0;
      c2_r    <= 8'd0;
      got_r   <= 2'd0;
      lits_r  <= 7'd0;
      clen_r  <= '0;
      cdist_r <= '0;
      endp_r  <= 1'b0;
      cons_r  <= 32'd0;
    end else if (step) begin
      phase_r <= phase_nxt;
      hl_r    <= hl_nxt;
      size_r  <= size_nxt;
      c0_r    <= c0_nxt;
      c1_r    <= c1_nxt;
      c2_r    <= c2_nxt;
      got_r   <= got_nxt;
      lits_r  <= lits_nxt;
      clen_r  <= clen_nxt;
      cdist_r <= cdist_nxt;
      endp_r  <= endp_nxt;
      cons_r  <= cons_nxt;
    end
  end

endmodule
`default_nettype wire

// File: sv/refpack_lz_decompressor_top.sv
// Top level of the streaming RefPack decompressor with its byte sequencer.
//
//   Channel  Direction  Handshake             Payload
//   in_      input      in_valid / in_ready   in_byte, in_begin_req
//   out_     output     out_valid / out_ready packed bytes, counts, flags, status
//
// An input byte is taken in idle; the sequencer then writes its literal byte,
// checks the distance of a copy, reads and then writes each copied byte, and
// offers each result that fills up and the last result of the byte. The single
// history memory port pair is read then written for each copied byte in turn.
// Reset clears the parser and sequencer; the history window needs no clearing.
// A stalled output holds the sequencer; no new byte is taken until the last
// result of the current byte has been transferred.
`timescale 1ns / 1ps
`default_nettype none
module refpack_lz_decompressor_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_byte,
  input  wire logic        in_begin_req,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      out_data_word0,
  output logic [63:0]      out_data_word1,
  output logic [63:0]      out_data_word2,
  output logic [63:0]      out_data_word3,
  output logic [5:0]       out_byte_count,
  output logic             out_last_of_run,
  output logic [23:0]      out_decoded_size,
  output logic             out_size_valid,
  output logic             out_stream_end,
  output logic [31:0]      out_consumed_bytes,
  output logic [1:0]       out_status
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_WORK = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_WR   = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]                       state_r, state_nxt, ret_r, ret_nxt;
  logic                             last_r, last_nxt;
  logic                             lit_pend_r, lit_pend_nxt;
  logic                             copy_pend_r, copy_pend_nxt;
  logic [7:0]                       lit_byte_r, lit_byte_nxt;
  logic [rlz_pkg::LEN_W-1:0]        left_r, left_nxt;
  logic [rlz_pkg::DIST_W-1:0]       dist_r, dist_nxt;
  logic [rlz_pkg::WIN_AW-1:0]       wr_pos_r, wr_pos_nxt;
  logic [rlz_pkg::PROD_W-1:0]       prod_r, prod_nxt;
  logic [1:0]                       status_r, status_nxt;
  logic                             sv_r, sv_nxt, se_r, se_nxt;
  logic [23:0]                      dsize_r, dsize_nxt;
  logic [31:0]                      cons_r, cons_nxt;

  rlz_pkg::act_t                    act;
  logic                             in_xfer, out_xfer;
  logic                             push, pk_full;
  logic [7:0]                       push_byte, rd_data;
  logic [rlz_pkg::CNT_W-1:0]        pk_count;
  logic [rlz_pkg::OUT_BYTES*8-1:0]  pk_data;
  logic                             ram_we, ram_re;
  logic [rlz_pkg::WIN_AW+rlz_pkg::DIST_W-1:0] rd_diff;
  logic [rlz_pkg::WIN_AW-1:0]       rd_addr;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign in_xfer   = in_valid && in_ready;
  assign out_xfer  = out_valid && out_ready;

  rlz_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (in_xfer),
    .in_byte   (in_byte),
    .begin_req (in_begin_req),
    .act       (act)
  );

  assign rd_diff = {{rlz_pkg::DIST_W{1'b0}}, wr_pos_r}
                 - {{rlz_pkg::WIN_AW{1'b0}}, dist_r};
  assign rd_addr = rd_diff[rlz_pkg::WIN_AW-1:0];

  rlz_hist_ram #(
    .DEPTH (rlz_pkg::WINDOW_BYTES),
    .WIDTH (8)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (wr_pos_r),
    .wr_data (push_byte),
    .rd_en   (ram_re),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  rlz_packer u_packer (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_byte (push_byte),
    .clear     (out_xfer),
    .full      (pk_full),
    .count     (pk_count),
    .data      (pk_data)
  );

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    last_nxt      = last_r;
    lit_pend_nxt  = lit_pend_r;
    copy_pend_nxt = copy_pend_r;
    lit_byte_nxt  = lit_byte_r;
    left_nxt      = left_r;
    dist_nxt      = dist_r;
    wr_pos_nxt    = wr_pos_r;
    prod_nxt      = prod_r;
    status_nxt    = status_r;
    sv_nxt        = sv_r;
    se_nxt        = se_r;
    dsize_nxt     = dsize_r;
    cons_nxt      = cons_r;
    push          = 1'b0;
    push_byte     = lit_byte_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          lit_pend_nxt  = act.emit_lit;
          lit_byte_nxt  = act.lit_byte;
          copy_pend_nxt = act.do_copy;
          left_nxt      = act.copy_len;
          dist_nxt      = act.copy_dist;
          status_nxt    = act.after_end ? rlz_pkg::ST_AFTER_END : rlz_pkg::ST_OK;
          sv_nxt        = act.size_valid;
          se_nxt        = act.stream_end;
          dsize_nxt     = act.decoded_size;
          cons_nxt      = act.consumed;
          if (act.restart) begin
            wr_pos_nxt = '0;
            prod_nxt   = '0;
          end
          state_nxt = S_WORK;
        end
      end
      S_WORK: begin
        if (lit_pend_r) begin
          if (pk_full) begin
            last_nxt  = 1'b0;
            ret_nxt   = S_WORK;
            state_nxt = S_OUT;
          end else begin
            push         = 1'b1;
            ram_we       = 1'b1;
            wr_pos_nxt   = wr_pos_r + 1'b1;
            if (prod_r != '1) begin
              prod_nxt = prod_r + 1'b1;
            end
            lit_pend_nxt = 1'b0;
          end
        end else if (copy_pend_r) begin
          copy_pend_nxt = 1'b0;
          if (rlz_pkg::PROD_W'(dist_r) > prod_r) begin
            status_nxt = rlz_pkg::ST_BAD_DIST;
          end else begin
            state_nxt = S_RD;
          end
        end else begin
          last_nxt  = 1'b1;
          state_nxt = S_OUT;
        end
      end
      S_RD: begin
        ram_re    = 1'b1;
        state_nxt = S_WR;
      end
      S_WR: begin
        push_byte = rd_data;
        if (pk_full) begin
          last_nxt  = 1'b0;
          ret_nxt   = S_WR;
          state_nxt = S_OUT;
        end else begin
          push       = 1'b1;
          ram_we     = 1'b1;
          wr_pos_nxt = wr_pos_r + 1'b1;
          if (prod_r != '1) begin
            prod_nxt = prod_r + 1'b1;
          end
          left_nxt  = left_r - 1'b1;
          state_nxt = (left_r == rlz_pkg::LEN_W'(1)) ? S_WORK : S_RD;
        end
      end
      S_OUT: begin
        if (out_xfer) begin
          state_nxt = last_r ? S_IDLE : ret_r;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_WORK;
      last_r      <= 1'b0;
      lit_pend_r  <= 1'b0;
      copy_pend_r <= 1'b0;
      wr_pos_r    <= '0;
      prod_r      <= '0;
      status_r    <= rlz_pkg::ST_OK;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      last_r      <= last_nxt;
      lit_pend_r  <= lit_pend_nxt;
      copy_pend_r <= copy_pend_nxt;
      wr_pos_r    <= wr_pos_nxt;
      prod_r      <= prod_nxt;
      status_r    <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lit_byte_r <= lit_byte_nxt;
    left_r     <= left_nxt;
    dist_r     <= dist_nxt;
    sv_r       <= sv_nxt;
    se_r       <= se_nxt;
    dsize_r    <= dsize_nxt;
    cons_r     <= cons_nxt;
  end

  assign out_data_word0     = pk_data[63:0];
  assign out_data_word1     = pk_data[127:64];
  assign out_data_word2     = pk_data[191:128];
  assign out_data_word3     = pk_data[255:192];
  assign out_byte_count     = pk_count;
  assign out_last_of_run    = last_r;
  assign out_decoded_size   = dsize_r;
  assign out_size_valid     = sv_r;
  assign out_stream_end     = se_r;
  assign out_consumed_bytes = cons_r;
  assign out_status         = status_r;

`ifndef NO_ASSERTIONS
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("result offered while input is open");
  a_full_nonlast: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_of_run) |-> (out_byte_count == 6'd32))
    else $error("non-final result is not full");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_byte_count <= 6'd32 && out_status != 2'd3))
    else $error("result count or status out of range");
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !pk_full)
    else $error("byte pushed into a full result");
`endif

endmodule
`default_nettype wire
